### rtl/core/tomq_pkg.sv
// Shared types and constants for the timestamp-ordered message queue.
// Holds the operation and status codes and the controller/datapath interface.
// No dependencies.
package tomq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 32;
    localparam int LEDGER_DEPTH_DEF = 64;
    localparam int MAX_POP          = 32;
    localparam int ID_W             = 64;
    localparam int TIME_W           = 64;
    localparam int OP_W             = 3;
    localparam int STATUS_W         = 4;
    localparam int COUNT_W          = 6;
    localparam int POP_CNT_W        = $clog2(MAX_POP + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE      = 3'd0,
        OP_RETRACT      = 3'd1,
        OP_RETRACT_PEND = 3'd2,
        OP_POP          = 3'd3,
        OP_DISCARD      = 3'd4,
        OP_QUERY        = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPLIED     = 4'd0,
        ST_BAD_ID      = 4'd1,
        ST_BAD_RCP     = 4'd2,
        ST_BAD_TIME    = 4'd3,
        ST_RETRACTED   = 4'd4,
        ST_DELIVERED   = 4'd5,
        ST_NOT_FOUND   = 4'd6,
        ST_QUEUE_FULL  = 4'd7,
        ST_LEDGER_FULL = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        SCAN_RET,
        SCAN_DEL,
        SCAN_RM_ID,
        SCAN_RM_RCP,
        SCAN_MIN,
        SCAN_BEST
    } scan_kind_t;

    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_COUNT,
        RES_QUERY
    } res_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ENQ_RET,
        S_ENQ_DEL,
        S_RT_DEL,
        S_RT_RET,
        S_RT_RM,
        S_POP_FIRST,
        S_POP_TAKE,
        S_POP_DEL,
        S_POP_NEXT,
        S_POP_EMIT,
        S_DISCARD,
        S_QUERY,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic       in_ready;
        logic       scan_start;
        scan_kind_t scan_kind;
        logic       save_del;
        logic       enq_write;
        logic       ret_append;
        logic       pop_take;
        logic       del_append;
        logic       res_set;
        status_t    res_status;
        res_sel_t   res_sel;
        logic       set_last;
        logic       res_last;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            mid_zero;
        logic            rid_zero;
        logic            time_bad;
        logic            scan_done;
        logic            hit;
        logic            found;
        logic            del_flag;
        logic            seq_zero;
        logic            queue_full;
        logic            ret_full;
        logic            rm_nonzero;
        logic            pop_limit;
        logic            p_last;
        logic            out_free;
    } dp_status_t;

endpackage

### rtl/core/tomq_ctrl.sv
// Controller state machine for the timestamp-ordered message queue.
// Sequences table and ledger scans; depends on tomq_pkg.
module tomq_ctrl
    import tomq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                case (sts.op) inside
                    OP_ENQUEUE:
                        state_next = (sts.mid_zero || sts.rid_zero || sts.time_bad)
                                     ? S_RESULT : S_ENQ_RET;
                    OP_RETRACT, OP_RETRACT_PEND:
                        state_next = sts.mid_zero ? S_RESULT : S_RT_DEL;
                    OP_POP:     state_next = sts.rid_zero ? S_RESULT : S_POP_FIRST;
                    OP_DISCARD: state_next = sts.rid_zero ? S_RESULT : S_DISCARD;
                    OP_QUERY:   state_next = sts.rid_zero ? S_RESULT : S_QUERY;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_ENQ_RET: begin
                if (sts.scan_done) state_next = sts.hit ? S_RESULT : S_ENQ_DEL;
            end
            S_ENQ_DEL: begin
                if (sts.scan_done) state_next = S_RESULT;
            end
            S_RT_DEL: begin
                if (sts.scan_done)
                    state_next = (sts.op == OP_RETRACT && sts.hit) ? S_RESULT : S_RT_RET;
            end
            S_RT_RET: begin
                if (sts.scan_done) state_next = sts.hit ? S_RESULT : S_RT_RM;
            end
            S_RT_RM: begin
                if (sts.scan_done) state_next = S_RESULT;
            end
            S_POP_FIRST: begin
                if (sts.scan_done) state_next = sts.found ? S_POP_TAKE : S_RESULT;
            end
            S_POP_TAKE: state_next = S_POP_DEL;
            S_POP_DEL: begin
                if (sts.scan_done) state_next = sts.pop_limit ? S_POP_EMIT : S_POP_NEXT;
            end
            S_POP_NEXT: begin
                if (sts.scan_done) state_next = S_POP_EMIT;
            end
            S_POP_EMIT: begin
                if (sts.out_free) state_next = sts.p_last ? S_IDLE : S_POP_TAKE;
            end
            S_DISCARD, S_QUERY: begin
                if (sts.scan_done) state_next = S_RESULT;
            end
            S_RESULT: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE: cmd.in_ready = 1'b1;
            S_DECODE: begin
                case (sts.op) inside
                    OP_ENQUEUE: begin
                        if (sts.mid_zero) begin
                            cmd.res_set = 1'b1; cmd.res_status = ST_BAD_ID;
                        end else if (sts.rid_zero) begin
                            cmd.res_set = 1'b1; cmd.res_status = ST_BAD_RCP;
                        end else if (sts.time_bad) begin
                            cmd.res_set = 1'b1; cmd.res_status = ST_BAD_TIME;
                        end else begin
                            cmd.scan_start = 1'b1; cmd.scan_kind = SCAN_RET;
                        end
                    end
                    OP_RETRACT, OP_RETRACT_PEND: begin
                        if (sts.mid_zero) begin
                            cmd.res_set = 1'b1; cmd.res_status = ST_BAD_ID;
                        end else begin
                            cmd.scan_start = 1'b1; cmd.scan_kind = SCAN_DEL;
                        end
                    end
                    OP_POP, OP_DISCARD, OP_QUERY: begin
                        if (sts.rid_zero) begin
                            cmd.res_set = 1'b1; cmd.res_status = ST_BAD_RCP;
                        end else begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_kind  = (sts.op == OP_POP) ? SCAN_BEST :
                                             (sts.op == OP_DISCARD) ? SCAN_RM_RCP : SCAN_MIN;
                        end
                    end
                    default: ;
                endcase
            end
            S_ENQ_RET: begin
                if (sts.scan_done) begin
                    if (sts.hit) begin
                        cmd.res_set = 1'b1; cmd.res_status = ST_RETRACTED;
                    end else begin
                        cmd.scan_start = 1'b1; cmd.scan_kind = SCAN_DEL;
                    end
                end
            end
            S_ENQ_DEL: begin
                if (sts.scan_done) begin
                    cmd.res_set = 1'b1;
                    if (sts.hit)             cmd.res_status = ST_DELIVERED;
                    else if (sts.seq_zero)   cmd.res_status = ST_BAD_ID;
                    else if (sts.queue_full) cmd.res_status = ST_QUEUE_FULL;
                    else begin
                        cmd.res_status = ST_APPLIED;
                        cmd.enq_write  = 1'b1;
                    end
                end
            end
            S_RT_DEL: begin
                if (sts.scan_done) begin
                    cmd.save_del = 1'b1;
                    if (sts.op == OP_RETRACT && sts.hit) begin
                        cmd.res_set = 1'b1; cmd.res_status = ST_DELIVERED;
                    end else begin
                        cmd.scan_start = 1'b1; cmd.scan_kind = SCAN_RET;
                    end
                end
            end
            S_RT_RET: begin
                if (sts.scan_done) begin
                    if (sts.hit) begin
                        cmd.res_set = 1'b1; cmd.res_status = ST_RETRACTED;
                    end else begin
                        cmd.scan_start = 1'b1; cmd.scan_kind = SCAN_RM_ID;
                    end
                end
            end
            S_RT_RM: begin
                if (sts.scan_done) begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_COUNT;
                    if (sts.rm_nonzero || (sts.op == OP_RETRACT_PEND && sts.del_flag)) begin
                        cmd.ret_append = 1'b1;
                        cmd.res_status = sts.ret_full ? ST_LEDGER_FULL : ST_APPLIED;
                    end else begin
                        cmd.res_status = ST_NOT_FOUND;
                    end
                end
            end
            S_POP_FIRST: begin
                if (sts.scan_done && !sts.found) begin
                    cmd.res_set = 1'b1; cmd.res_status = ST_NOT_FOUND;
                end
            end
            S_POP_TAKE: begin
                cmd.pop_take   = 1'b1;
                cmd.scan_start = 1'b1;
                cmd.scan_kind  = SCAN_DEL;
            end
            S_POP_DEL: begin
                if (sts.scan_done) begin
                    cmd.del_append = 1'b1;
                    if (sts.pop_limit) begin
                        cmd.set_last = 1'b1; cmd.res_last = 1'b1;
                    end else begin
                        cmd.scan_start = 1'b1; cmd.scan_kind = SCAN_BEST;
                    end
                end
            end
            S_POP_NEXT: begin
                if (sts.scan_done) begin
                    cmd.set_last = 1'b1;
                    cmd.res_last = !sts.found;
                end
            end
            S_POP_EMIT, S_RESULT: cmd.out_load = sts.out_free;
            S_DISCARD: begin
                if (sts.scan_done) begin
                    cmd.res_set = 1'b1; cmd.res_status = ST_APPLIED; cmd.res_sel = RES_COUNT;
                end
            end
            S_QUERY: begin
                if (sts.scan_done) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_sel    = RES_QUERY;
                    cmd.res_status = sts.found ? ST_APPLIED : ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/core/tomq_dp.sv
// Datapath for the timestamp-ordered message queue: entry table, ledgers,
// scan engine and result registers. Depends on tomq_pkg.
module tomq_dp
    import tomq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int LEDGER_DEPTH = LEDGER_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          sts,
    input  logic                s_valid,
    input  logic [OP_W-1:0]     s_op,
    input  logic [ID_W-1:0]     s_message_id,
    input  logic [ID_W-1:0]     s_recipient_id,
    input  logic [TIME_W-1:0]   s_time_value,
    input  logic                s_inclusive,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [COUNT_W-1:0]  m_count,
    output logic [ID_W-1:0]     m_out_message_id,
    output logic [ID_W-1:0]     m_out_recipient_id,
    output logic [TIME_W-1:0]   m_out_time,
    output logic                m_last
);

    localparam int QIW  = $clog2(QUEUE_DEPTH);
    localparam int LIW  = $clog2(LEDGER_DEPTH);
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int LCW  = $clog2(LEDGER_DEPTH + 1);
    localparam int MAXD = (QUEUE_DEPTH > LEDGER_DEPTH) ? QUEUE_DEPTH : LEDGER_DEPTH;
    localparam int PW   = $clog2(MAXD + 1);

    typedef struct packed {
        logic [ID_W-1:0]   mid;
        logic [ID_W-1:0]   rid;
        logic [TIME_W-1:0] tm;
        logic [63:0]       seq;
    } entry_t;

    // request capture
    logic [OP_W-1:0]   op_reg;
    logic [ID_W-1:0]   mid_reg, rid_reg, key_reg;
    logic [TIME_W-1:0] tv_reg;
    logic              incl_reg;
    logic              accept;

    assign accept = s_valid && cmd.in_ready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_op;
            mid_reg  <= s_message_id;
            rid_reg  <= s_recipient_id;
            tv_reg   <= s_time_value;
            incl_reg <= s_inclusive;
        end
    end

    // memories
    entry_t          ent_mem [QUEUE_DEPTH];
    logic [ID_W-1:0] ret_mem [LEDGER_DEPTH];
    logic [ID_W-1:0] del_mem [LEDGER_DEPTH];
    entry_t          ent_rd_reg;
    logic [ID_W-1:0] ret_rd_reg, del_rd_reg;

    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [63:0]            seq_reg;
    logic [LCW-1:0]         ret_cnt_reg, del_cnt_reg;
    logic                   ret_full, del_full;

    // scan engine state
    scan_kind_t     kind_reg;
    logic           busy_reg, rd_vld_reg;
    logic [PW-1:0]  ptr_reg, rd_idx_reg, scan_len;
    logic           issue, scan_done;
    logic           hit_reg, found_reg, del_flag_reg;
    logic [QIW-1:0] best_idx_reg, free_idx;
    logic [TIME_W-1:0] best_time_reg;
    logic [63:0]    best_seq_reg;
    logic [ID_W-1:0] best_mid_reg;
    logic [QCW-1:0] rm_cnt_reg;
    logic [POP_CNT_W-1:0] pop_cnt_reg;

    // pending result
    logic [STATUS_W-1:0] p_status_reg;
    logic [COUNT_W-1:0]  p_count_reg;
    logic [ID_W-1:0]     p_mid_reg, p_rid_reg;
    logic [TIME_W-1:0]   p_time_reg;
    logic                p_last_reg;

    // output register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    logic [ID_W-1:0]     m_mid_reg, m_rid_reg;
    logic [TIME_W-1:0]   m_time_reg;
    logic                m_last_reg;

    assign ret_full = (ret_cnt_reg == LCW'(LEDGER_DEPTH));
    assign del_full = (del_cnt_reg == LCW'(LEDGER_DEPTH));

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) free_idx = QIW'(i);
        end
    end

    // scan length by kind
    always_comb begin
        case (kind_reg)
            SCAN_RET: scan_len = PW'(ret_cnt_reg);
            SCAN_DEL: scan_len = PW'(del_cnt_reg);
            default:  scan_len = PW'(QUEUE_DEPTH);
        endcase
    end

    assign issue     = busy_reg && (ptr_reg < scan_len);
    assign scan_done = busy_reg && !issue && !rd_vld_reg;

    // memory writes and registered reads
    always_ff @(posedge aclk) begin
        if (cmd.enq_write) ent_mem[free_idx] <= '{mid: mid_reg, rid: rid_reg,
                                                  tm: tv_reg, seq: seq_reg};
        if (cmd.ret_append && !ret_full) ret_mem[ret_cnt_reg[LIW-1:0]] <= key_reg;
        if (cmd.del_append && !hit_reg && !del_full)
            del_mem[del_cnt_reg[LIW-1:0]] <= key_reg;
        ent_rd_reg <= ent_mem[ptr_reg[QIW-1:0]];
        ret_rd_reg <= ret_mem[ptr_reg[LIW-1:0]];
        del_rd_reg <= del_mem[ptr_reg[LIW-1:0]];
    end

    // compare of the entry read this cycle
    logic           e_valid, e_rcp, e_elig, e_better, e_min;
    logic [QIW-1:0] e_idx;

    always_comb begin
        e_idx    = rd_idx_reg[QIW-1:0];
        e_valid  = rd_vld_reg && valid_reg[e_idx];
        e_rcp    = e_valid && (ent_rd_reg.rid == rid_reg);
        e_elig   = (ent_rd_reg.tm < tv_reg) || (incl_reg && ent_rd_reg.tm == tv_reg);
        e_better = !found_reg || (ent_rd_reg.tm < best_time_reg) ||
                   (ent_rd_reg.tm == best_time_reg && ent_rd_reg.seq < best_seq_reg);
        e_min    = !found_reg || (ent_rd_reg.tm < best_time_reg);
    end

    // entry valid bits
    always_comb begin
        valid_next = valid_reg;
        if (cmd.enq_write) valid_next[free_idx] = 1'b1;
        if (cmd.pop_take)  valid_next[best_idx_reg] = 1'b0;
        if ((kind_reg == SCAN_RM_ID && e_valid && ent_rd_reg.mid == key_reg) ||
            (kind_reg == SCAN_RM_RCP && e_rcp))
            valid_next[e_idx] = 1'b0;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            seq_reg     <= 64'd1;
            ret_cnt_reg <= '0;
            del_cnt_reg <= '0;
            busy_reg    <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            if (cmd.enq_write) seq_reg <= seq_reg + 64'd1;
            if (cmd.ret_append && !ret_full) ret_cnt_reg <= ret_cnt_reg + LCW'(1);
            if (cmd.del_append && !hit_reg && !del_full) del_cnt_reg <= del_cnt_reg + LCW'(1);
            rd_vld_reg <= issue;
            if (cmd.scan_start)  busy_reg <= 1'b1;
            else if (scan_done)  busy_reg <= 1'b0;
            if (cmd.out_load)    m_valid_reg <= 1'b1;
            else if (m_ready)    m_valid_reg <= 1'b0;
        end
    end

    // scan datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg     <= s_message_id;
            pop_cnt_reg <= '0;
        end
        if (cmd.scan_start) begin
            kind_reg   <= cmd.scan_kind;
            ptr_reg    <= '0;
            hit_reg    <= 1'b0;
            found_reg  <= 1'b0;
            rm_cnt_reg <= '0;
        end else begin
            if (issue) ptr_reg <= ptr_reg + PW'(1);
            if (rd_vld_reg) begin
                case (kind_reg)
                    SCAN_RET: if (ret_rd_reg == key_reg) hit_reg <= 1'b1;
                    SCAN_DEL: if (del_rd_reg == key_reg) hit_reg <= 1'b1;
                    SCAN_RM_ID: begin
                        if (e_valid && ent_rd_reg.mid == key_reg)
                            rm_cnt_reg <= rm_cnt_reg + QCW'(1);
                    end
                    SCAN_RM_RCP: if (e_rcp) rm_cnt_reg <= rm_cnt_reg + QCW'(1);
                    SCAN_MIN: begin
                        if (e_rcp && e_min) begin
                            found_reg     <= 1'b1;
                            best_time_reg <= ent_rd_reg.tm;
                        end
                    end
                    SCAN_BEST: begin
                        if (e_rcp && e_elig && e_better) begin
                            found_reg     <= 1'b1;
                            best_idx_reg  <= e_idx;
                            best_time_reg <= ent_rd_reg.tm;
                            best_seq_reg  <= ent_rd_reg.seq;
                            best_mid_reg  <= ent_rd_reg.mid;
                        end
                    end
                    default: ;
                endcase
            end
        end
        rd_idx_reg <= ptr_reg;
        if (cmd.save_del) del_flag_reg <= hit_reg;
        if (cmd.pop_take) begin
            key_reg     <= best_mid_reg;
            pop_cnt_reg <= pop_cnt_reg + POP_CNT_W'(1);
        end
    end

    // pending result fields
    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            p_status_reg <= cmd.res_status;
            p_count_reg  <= (cmd.res_sel == RES_COUNT) ? COUNT_W'(rm_cnt_reg) : '0;
            p_mid_reg    <= '0;
            p_rid_reg    <= '0;
            p_time_reg   <= (cmd.res_sel == RES_QUERY && found_reg) ? best_time_reg : '0;
            p_last_reg   <= 1'b1;
        end
        if (cmd.pop_take) begin
            p_count_reg <= '0;
            p_mid_reg   <= best_mid_reg;
            p_rid_reg   <= rid_reg;
            p_time_reg  <= best_time_reg;
        end
        if (cmd.del_append)
            p_status_reg <= (!hit_reg && del_full) ? ST_LEDGER_FULL : ST_APPLIED;
        if (cmd.set_last) p_last_reg <= cmd.res_last;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= p_status_reg;
            m_count_reg  <= p_count_reg;
            m_mid_reg    <= p_mid_reg;
            m_rid_reg    <= p_rid_reg;
            m_time_reg   <= p_time_reg;
            m_last_reg   <= p_last_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_count            = m_count_reg;
    assign m_out_message_id   = m_mid_reg;
    assign m_out_recipient_id = m_rid_reg;
    assign m_out_time         = m_time_reg;
    assign m_last             = m_last_reg;

    // status to controller
    always_comb begin
        sts.op         = op_reg;
        sts.mid_zero   = (mid_reg == '0);
        sts.rid_zero   = (rid_reg == '0);
        sts.time_bad   = (tv_reg == '0) || (&tv_reg);
        sts.scan_done  = scan_done;
        sts.hit        = hit_reg;
        sts.found      = found_reg;
        sts.del_flag   = del_flag_reg;
        sts.seq_zero   = (seq_reg == '0);
        sts.queue_full = &valid_reg;
        sts.ret_full   = ret_full;
        sts.rm_nonzero = (rm_cnt_reg != '0);
        sts.pop_limit  = (pop_cnt_reg == POP_CNT_W'(MAX_POP));
        sts.p_last     = p_last_reg;
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // checks; a new scan may chain off the one finishing this cycle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_start |-> (!busy_reg || scan_done))
        else $error("scan started while busy");
    a_pop_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop_take |-> (pop_cnt_reg < POP_CNT_W'(MAX_POP)))
        else $error("pop exceeded limit");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output overwritten");
    a_ledger_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ret_cnt_reg <= LCW'(LEDGER_DEPTH)) && (del_cnt_reg <= LCW'(LEDGER_DEPTH)))
        else $error("ledger count overflow");

endmodule

### rtl/core/timestamp_order_message_queue.sv
// Top level of the timestamp-ordered message queue.
// Instantiates tomq_ctrl and tomq_dp; depends on tomq_pkg.
//
//  Channel   Ports      Direction  Carries
//  input     s_*        in         op, message_id, recipient_id, time_value, inclusive
//  result    m_*        out        status, count, out_message_id/recipient_id/time, last
//
// One item at a time. Each ledger lookup walks its filled entries and each
// table pass all QUEUE_DEPTH slots, through one registered memory port.
// Pop costs one table pass, then per popped entry one delivered-ledger pass,
// one more table pass (skipped at the pop limit) and a step to take the entry.
// Synchronous active-low reset empties the table and both ledgers at once.
// A stalled result holds in the output register; the next item is accepted
// and processed, and only its own result waits for the register to free.
module timestamp_order_message_queue
    import tomq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int LEDGER_DEPTH = LEDGER_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [ID_W-1:0]     s_message_id,
    input  logic [ID_W-1:0]     s_recipient_id,
    input  logic [TIME_W-1:0]   s_time_value,
    input  logic                s_inclusive,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [COUNT_W-1:0]  m_count,
    output logic [ID_W-1:0]     m_out_message_id,
    output logic [ID_W-1:0]     m_out_recipient_id,
    output logic [TIME_W-1:0]   m_out_time,
    output logic                m_last
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    assign s_ready = cmd.in_ready;

    tomq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    tomq_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .LEDGER_DEPTH (LEDGER_DEPTH)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_valid            (s_valid),
        .s_op               (s_op),
        .s_message_id       (s_message_id),
        .s_recipient_id     (s_recipient_id),
        .s_time_value       (s_time_value),
        .s_inclusive        (s_inclusive),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_count            (m_count),
        .m_out_message_id   (m_out_message_id),
        .m_out_recipient_id (m_out_recipient_id),
        .m_out_time         (m_out_time),
        .m_last             (m_last)
    );

endmodule

### test/tb_timestamp_order_message_queue.sv
// Self-checking testbench for timestamp_order_message_queue.
// Drives directed and random transactions, predicts every result in-bench.
// Depends on tomq_pkg and the RTL top level only.
module tb_timestamp_order_message_queue
    import tomq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int LD = LEDGER_DEPTH_DEF;
    localparam int DLV = 0;
    localparam int RTR = 1;
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;
    localparam logic [63:0] T_FINAL = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [3:0]  status;
        logic [5:0]  count;
        logic [63:0] mid;
        logic [63:0] rid;
        logic [63:0] t;
        logic        last;
    } result_t;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [63:0]     mid;
        logic [63:0]     rid;
        logic [63:0]     tv;
        logic            incl;
        logic            typed;
        status_t         xstatus;
    } stim_row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [OP_W-1:0] s_op = '0;
    logic [63:0] s_message_id = '0, s_recipient_id = '0, s_time_value = '0;
    logic s_inclusive = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [STATUS_W-1:0] m_status;
    logic [COUNT_W-1:0] m_count;
    logic [63:0] m_out_message_id, m_out_recipient_id, m_out_time;
    logic m_last;

    timestamp_order_message_queue uut (.*);

    always #2 aclk = ~aclk;

    // Shadow copy of the queue table and both id ledgers
    logic        q_valid [QD];
    logic [63:0] q_mid [QD], q_rid [QD], q_time [QD], q_seq [QD];
    logic [63:0] seq_next;
    logic [63:0] ledger [2][LD];
    int          ledger_cnt [2];

    result_t expected_results[$];
    int      errors = 0;
    bit      quiet = 0;
    logic [63:0] fresh_id = 64'd100;

    function automatic bit ledger_has(int w, logic [63:0] id);
        for (int i = 0; i < ledger_cnt[w]; i++)
            if (ledger[w][i] == id) return 1;
        return 0;
    endfunction

    // returns 0 when a new id is dropped by a full ledger
    function automatic bit ledger_add(int w, logic [63:0] id);
        if (ledger_has(w, id)) return 1;
        if (ledger_cnt[w] >= LD) return 0;
        ledger[w][ledger_cnt[w]] = id;
        ledger_cnt[w]++;
        return 1;
    endfunction

    function automatic void push_result(status_t st, int n, logic [63:0] mid,
                                        logic [63:0] rid, logic [63:0] t, bit lst);
        result_t r;
        r.status = st;
        r.count = n[5:0];
        r.mid = mid;
        r.rid = rid;
        r.t = t;
        r.last = lst;
        expected_results = {expected_results, r};
    endfunction

    // Apply one accepted transaction to the shadow state, queue its results
    function automatic void apply_message_op(logic [OP_W-1:0] op, logic [63:0] mid,
                                             logic [63:0] rid, logic [63:0] tv,
                                             logic incl);
        status_t st;
        int n, slot, best, k;
        bit del, found;
        logic [63:0] tmin;
        st = ST_APPLIED;
        n = 0;
        case (op)
            OP_ENQUEUE: begin
                if (mid == 0) st = ST_BAD_ID;
                else if (rid == 0) st = ST_BAD_RCP;
                else if (tv == 0 || tv == T_FINAL) st = ST_BAD_TIME;
                else if (ledger_has(RTR, mid)) st = ST_RETRACTED;
                else if (ledger_has(DLV, mid)) st = ST_DELIVERED;
                else if (seq_next == 0) st = ST_BAD_ID;
                else begin
                    slot = -1;
                    for (int i = 0; i < QD; i++)
                        if (!q_valid[i] && slot < 0) slot = i;
                    if (slot < 0) st = ST_QUEUE_FULL;
                    else begin
                        q_valid[slot] = 1;
                        q_mid[slot] = mid;
                        q_rid[slot] = rid;
                        q_time[slot] = tv;
                        q_seq[slot] = seq_next;
                        seq_next++;
                    end
                end
                push_result(st, 0, 0, 0, 0, 1);
            end
            OP_RETRACT, OP_RETRACT_PEND: begin
                del = mid != 0 && ledger_has(DLV, mid);
                if (mid == 0) st = ST_BAD_ID;
                else if (op == OP_RETRACT && del) st = ST_DELIVERED;
                else if (ledger_has(RTR, mid)) st = ST_RETRACTED;
                else begin
                    for (int i = 0; i < QD; i++)
                        if (q_valid[i] && q_mid[i] == mid) begin
                            q_valid[i] = 0;
                            n++;
                        end
                    if (n != 0 || (op == OP_RETRACT_PEND && del))
                        st = ledger_add(RTR, mid) ? ST_APPLIED : ST_LEDGER_FULL;
                    else
                        st = ST_NOT_FOUND;
                end
                push_result(st, n, 0, 0, 0, 1);
            end
            OP_POP: begin
                if (rid == 0) push_result(ST_BAD_RCP, 0, 0, 0, 0, 1);
                else begin
                    k = 0;
                    best = 0;
                    // repeated minimum search over (time, sequence)
                    while (k < MAX_POP && best >= 0) begin
                        best = -1;
                        for (int i = 0; i < QD; i++)
                            if (q_valid[i] && q_rid[i] == rid &&
                                (q_time[i] < tv || (incl && q_time[i] == tv)))
                                if (best < 0 || q_time[i] < q_time[best] ||
                                    (q_time[i] == q_time[best] &&
                                     q_seq[i] < q_seq[best]))
                                    best = i;
                        if (best >= 0) begin
                            q_valid[best] = 0;
                            st = ledger_add(DLV, q_mid[best]) ? ST_APPLIED
                                                              : ST_LEDGER_FULL;
                            push_result(st, 0, q_mid[best], q_rid[best],
                                        q_time[best], 0);
                            k++;
                        end
                    end
                    if (k == 0) push_result(ST_NOT_FOUND, 0, 0, 0, 0, 1);
                    else expected_results[$].last = 1;
                end
            end
            OP_DISCARD: begin
                if (rid == 0) push_result(ST_BAD_RCP, 0, 0, 0, 0, 1);
                else begin
                    for (int i = 0; i < QD; i++)
                        if (q_valid[i] && q_rid[i] == rid) begin
                            q_valid[i] = 0;
                            n++;
                        end
                    push_result(ST_APPLIED, n, 0, 0, 0, 1);
                end
            end
            OP_QUERY: begin
                if (rid == 0) push_result(ST_BAD_RCP, 0, 0, 0, 0, 1);
                else begin
                    found = 0;
                    tmin = 0;
                    for (int i = 0; i < QD; i++)
                        if (q_valid[i] && q_rid[i] == rid && (!found || q_time[i] < tmin)) begin
                            tmin = q_time[i];
                            found = 1;
                        end
                    push_result(found ? ST_APPLIED : ST_NOT_FOUND, 0, 0, 0, tmin, 1);
                end
            end
            default: ;
        endcase
    endfunction

    // Send one transaction; predict on acceptance
    task automatic send(stim_row_t row);
        int gap, before_n;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
        if (gap != 0) begin
            s_valid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1;
        s_op = row.op;
        s_message_id = row.mid;
        s_recipient_id = row.rid;
        s_time_value = row.tv;
        s_inclusive = row.incl;
        do @(posedge aclk); while (!s_ready);
        before_n = expected_results.size();
        apply_message_op(row.op, row.mid, row.rid, row.tv, row.incl);
        if (row.typed) expected_results[before_n].status = row.xstatus;
        @(negedge aclk);
        s_valid = 0;
    endtask

    task automatic send_op(logic [OP_W-1:0] op, logic [63:0] mid, logic [63:0] rid,
                           logic [63:0] tv, logic incl);
        stim_row_t r;
        r = '{op, mid, rid, tv, incl, 1'b0, ST_APPLIED};
        send(r);
    endtask

    // Result channel backpressure in bursts, off once quiet is set
    initial begin
        int len;
        while (1) begin
            @(negedge aclk);
            m_ready = 1;
            len = $urandom_range(1, 30);
            repeat (len) @(negedge aclk);
            if (!quiet) begin
                m_ready = 0;
                len = $urandom_range(1, 15);
                repeat (len) @(negedge aclk);
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%t: unexpected result status=%0d mid=%h", $realtime,
                         m_status, m_out_message_id);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (m_status !== e.status || m_count !== e.count ||
                    m_out_message_id !== e.mid || m_out_recipient_id !== e.rid ||
                    m_out_time !== e.t || m_last !== e.last) begin
                    $display("%t: mismatch expected st=%0d cnt=%0d mid=%h rid=%h t=%h last=%b",
                             $realtime, e.status, e.count, e.mid, e.rid, e.t, e.last);
                    $display("%t:          actual   st=%0d cnt=%0d mid=%h rid=%h t=%h last=%b",
                             $realtime, m_status, m_count, m_out_message_id,
                             m_out_recipient_id, m_out_time, m_last);
                    errors++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #30_000_000;
        $display("** timestamp_order_message_queue: FAILED **");
        $finish;
    end

    stim_row_t directed[] = '{
        '{OP_ENQUEUE, 64'd0, 64'd7, 64'd10, 1'b0, 1'b1, ST_BAD_ID},
        '{OP_ENQUEUE, 64'd5, 64'd0, 64'd10, 1'b0, 1'b1, ST_BAD_RCP},
        '{OP_ENQUEUE, 64'd5, 64'd7, 64'd0, 1'b0, 1'b1, ST_BAD_TIME},
        '{OP_ENQUEUE, 64'd5, 64'd7, T_FINAL, 1'b0, 1'b1, ST_BAD_TIME},
        '{OP_ENQUEUE, T_FINAL, T_FINAL, T_FINAL - 1, 1'b1, 1'b1, ST_APPLIED},
        '{OP_ENQUEUE, 64'd5, 64'd7, 64'd100, 1'b0, 1'b0, ST_APPLIED},
        '{OP_ENQUEUE, 64'd6, 64'd7, 64'd100, 1'b0, 1'b0, ST_APPLIED},
        '{OP_ENQUEUE, 64'd7, 64'd7, 64'd50, 1'b0, 1'b0, ST_APPLIED},
        '{OP_ENQUEUE, 64'd5, 64'd7, 64'd10, 1'b0, 1'b0, ST_APPLIED},
        '{OP_QUERY, 64'd0, 64'd0, 64'd0, 1'b0, 1'b1, ST_BAD_RCP},
        '{OP_QUERY, 64'd0, 64'd7, 64'd0, 1'b0, 1'b0, ST_APPLIED},
        '{OP_QUERY, 64'd0, 64'd9, 64'd0, 1'b0, 1'b1, ST_NOT_FOUND},
        '{OP_POP, 64'd0, 64'd0, 64'd100, 1'b0, 1'b1, ST_BAD_RCP},
        '{OP_POP, 64'd0, 64'd7, 64'd100, 1'b0, 1'b0, ST_APPLIED},
        '{OP_POP, 64'd0, 64'd7, 64'd100, 1'b1, 1'b0, ST_APPLIED},
        '{OP_POP, 64'd0, 64'd7, T_FINAL, 1'b1, 1'b1, ST_NOT_FOUND},
        '{OP_ENQUEUE, 64'd5, 64'd7, 64'd30, 1'b0, 1'b1, ST_DELIVERED},
        '{OP_RETRACT, 64'd0, 64'd0, 64'd0, 1'b0, 1'b1, ST_BAD_ID},
        '{OP_RETRACT, 64'd5, 64'd0, 64'd0, 1'b0, 1'b1, ST_DELIVERED},
        '{OP_RETRACT_PEND, 64'd5, 64'd0, 64'd0, 1'b0, 1'b0, ST_APPLIED},
        '{OP_ENQUEUE, 64'd5, 64'd7, 64'd30, 1'b0, 1'b1, ST_RETRACTED},
        '{OP_RETRACT, 64'd99, 64'd0, 64'd0, 1'b0, 1'b1, ST_NOT_FOUND},
        '{OP_DISCARD, 64'd0, 64'd0, 64'd0, 1'b0, 1'b1, ST_BAD_RCP},
        '{OP_DISCARD, 64'd0, T_FINAL, 64'd0, 1'b0, 1'b0, ST_APPLIED},
        '{OP_UNDEF_LO, 64'd1, 64'd1, 64'd1, 1'b0, 1'b0, ST_APPLIED},
        '{OP_UNDEF_HI, T_FINAL, T_FINAL, T_FINAL, 1'b1, 1'b0, ST_APPLIED}
    };

    function automatic logic [63:0] pick_id();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            fresh_id++;
            return fresh_id;
        end
        if (sel < 94) return fresh_id - $urandom_range(0, 10);
        if (sel < 97) return {$urandom, $urandom};
        return 64'd0;
    endfunction

    function automatic logic [63:0] pick_rcp();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 88) return 64'($urandom_range(1, 4));
        if (sel < 96) return {$urandom, $urandom};
        return 64'd0;
    endfunction

    function automatic logic [63:0] pick_time();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) return 64'($urandom_range(1, 60));
        if (sel < 94) return {$urandom, $urandom};
        if (sel < 97) return T_FINAL;
        return 64'd0;
    endfunction

    task automatic random_items(int n);
        int sel;
        logic [OP_W-1:0] op;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 42) op = OP_ENQUEUE;
            else if (sel < 62) op = OP_POP;
            else if (sel < 72) op = OP_QUERY;
            else if (sel < 82) op = OP_RETRACT;
            else if (sel < 90) op = OP_RETRACT_PEND;
            else if (sel < 96) op = OP_DISCARD;
            else op = 3'($urandom_range(6, 7));
            if (i == n / 2) begin
                wait (expected_results.size() == 0);
                @(negedge aclk);
            end
            send_op(op, pick_id(), pick_rcp(), pick_time(), 1'($urandom));
        end
    endtask

    // Stimulus
    initial begin
        logic [63:0] base;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        for (int i = 0; i < QD; i++) q_valid[i] = 0;
        seq_next = 1;
        ledger_cnt[DLV] = 0;
        ledger_cnt[RTR] = 0;

        foreach (directed[i]) send(directed[i]);
        random_items(70);

        // Clear the table, fill and drain it twice, fill it once more, then
        // retract every id; this overruns the delivered and retracted ledgers.
        for (int r = 1; r <= 4; r++) send_op(OP_DISCARD, 0, 64'(r), 0, 0);
        base = fresh_id;
        for (int b = 0; b < 3; b++) begin
            for (int i = 0; i < QD + 1; i++) begin
                fresh_id++;
                send_op(OP_ENQUEUE, fresh_id, 64'hA5A5_0000_0000_0001,
                        64'($urandom_range(1, 20)), 0);
            end
            if (b < 2) send_op(OP_POP, 0, 64'hA5A5_0000_0000_0001, T_FINAL, 1);
        end
        for (logic [63:0] id = base + 1; id <= fresh_id; id++)
            send_op(OP_RETRACT_PEND, id, 0, 0, 0);

        quiet = 1;
        random_items(60);

        wait (expected_results.size() == 0);
        repeat (400) @(posedge aclk);
        if (errors == 0)
            $display("** timestamp_order_message_queue: PASSED **");
        else
            $display("** timestamp_order_message_queue: FAILED **");
        $finish;
    end
endmodule
